// ===== rtl/pscp_pkg.sv =====
// ----------------------------------------------------------------------------
// pscp_pkg
// Types, codes and field tables of the PDU session container parser.
// ----------------------------------------------------------------------------
package pscp_pkg;

  localparam int unsigned PhaseW = 12;

  // parser phase, one-hot
  typedef enum logic [PhaseW-1:0] {
    PH_IDLE     = 12'b0000_0000_0001,
    PH_OCT2     = 12'b0000_0000_0010,
    PH_PPI      = 12'b0000_0000_0100,
    PH_DL_SEND  = 12'b0000_0000_1000,
    PH_DL_SEQ   = 12'b0000_0001_0000,
    PH_TS_REP   = 12'b0000_0010_0000,
    PH_RECV     = 12'b0000_0100_0000,
    PH_UL_SEND  = 12'b0000_1000_0000,
    PH_DL_DELAY = 12'b0001_0000_0000,
    PH_UL_DELAY = 12'b0010_0000_0000,
    PH_UL_SEQ   = 12'b0100_0000_0000,
    PH_PAD      = 12'b1000_0000_0000
  } phase_e;

  // result kind codes
  typedef enum logic [3:0] {
    KIND_HEADER     = 4'd0,
    KIND_DL_SEND_TS = 4'd1,
    KIND_DL_SEQ     = 4'd2,
    KIND_DL_TS_REP  = 4'd3,
    KIND_DL_RECV_TS = 4'd4,
    KIND_UL_SEND_TS = 4'd5,
    KIND_DL_DELAY   = 4'd6,
    KIND_UL_DELAY   = 4'd7,
    KIND_UL_SEQ     = 4'd8,
    KIND_PAD_DONE   = 4'd9,
    KIND_ERROR      = 4'd10
  } kind_e;

  localparam logic [3:0] PduTypeDl = 4'd0;
  localparam logic [3:0] PduTypeUl = 4'd1;

  typedef struct packed {
    logic ul;
    logic ppp;
    logic qmp;
    logic dld;
    logic uld;
    logic snp;
  } flags_t;

  typedef struct packed {
    logic [5:0] qfi;
    logic       rqi;
    logic [2:0] ppi;
  } header_t;

  function automatic logic [3:0] field_len(phase_e ph);
    logic [3:0] len;
    unique case (ph)
      PH_PPI:      len = 4'd1;
      PH_DL_SEND:  len = 4'd8;
      PH_DL_SEQ:   len = 4'd3;
      PH_TS_REP:   len = 4'd8;
      PH_RECV:     len = 4'd8;
      PH_UL_SEND:  len = 4'd8;
      PH_DL_DELAY: len = 4'd4;
      PH_UL_DELAY: len = 4'd4;
      PH_UL_SEQ:   len = 4'd3;
      default:     len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic kind_e field_kind(phase_e ph);
    kind_e k;
    unique case (ph)
      PH_DL_SEND:  k = KIND_DL_SEND_TS;
      PH_DL_SEQ:   k = KIND_DL_SEQ;
      PH_TS_REP:   k = KIND_DL_TS_REP;
      PH_RECV:     k = KIND_DL_RECV_TS;
      PH_UL_SEND:  k = KIND_UL_SEND_TS;
      PH_DL_DELAY: k = KIND_DL_DELAY;
      PH_UL_DELAY: k = KIND_UL_DELAY;
      PH_UL_SEQ:   k = KIND_UL_SEQ;
      PH_PAD:      k = KIND_PAD_DONE;
      default:     k = KIND_HEADER;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/pdu_session_container_parser.sv =====
// ----------------------------------------------------------------------------
// pdu_session_container_parser
// Octet-serial parser of a PDU session container extension-header body.
// ----------------------------------------------------------------------------
// Takes one octet per clock cycle, with start_req_i marking the first octet of
// a container. The header octets and every optional field (PPI, timestamps,
// delay results, QFI sequence) are decoded on the fly; each completed field,
// the header, the end of padding or a bad PDU type gives one result beat in
// the cycle after its last octet is taken. Results sit in a single output
// register: in_ready_o is high whenever that register is empty or drains in
// the same cycle, so the sustained rate is one octet per cycle and only a
// stalled result consumer slows the input.
module pdu_session_container_parser
  import pscp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  kind_o,
  output logic [63:0] value_o,
  output logic        pdu_type_o,
  output logic        qmp_o,
  output logic [5:0]  qfi_o,
  output logic        rqi_o,
  output logic        ppi_present_o,
  output logic [2:0]  ppi_o,
  output logic        last_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  bytes_q, bytes_d;
  logic [63:0] acc_q, acc_d;
  flags_t      flags_q, flags_d;
  header_t     hdr_q, hdr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  pad_q, pad_d;

  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [63:0] value_q, value_d;
  logic        last_q, last_d;
  flags_t      oflags_q;
  header_t     ohdr_q;

  logic        accept;
  logic        emit;
  logic [1:0]  cnt_inc;
  logic [1:0]  pad_need;
  flags_t      flags_adv;
  logic [PhaseW-1:0] applies, above, cand, lowest;
  phase_e      nxt_ph;
  logic [63:0] acc_shift;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cnt_inc   = cnt_q + 2'd1;
  assign pad_need  = 2'd2 - cnt_inc;
  assign acc_shift = {acc_q[55:0], data_byte_i};

  // the ppi-present flag from the second octet counts for the next phase
  always_comb begin
    flags_adv = flags_q;
    if (phase_q == PH_OCT2 && !flags_q.ul) begin
      flags_adv.ppp = data_byte_i[7];
    end
  end

  // next applicable phase: lowest set bit above the current one
  always_comb begin
    applies                       = '0;
    applies[$clog2(PH_PPI)]       = !flags_adv.ul && flags_adv.ppp;
    applies[$clog2(PH_DL_SEND)]   = !flags_adv.ul && flags_adv.qmp;
    applies[$clog2(PH_DL_SEQ)]    = !flags_adv.ul && flags_adv.snp;
    applies[$clog2(PH_TS_REP)]    = flags_adv.ul && flags_adv.qmp;
    applies[$clog2(PH_RECV)]      = flags_adv.ul && flags_adv.qmp;
    applies[$clog2(PH_UL_SEND)]   = flags_adv.ul && flags_adv.qmp;
    applies[$clog2(PH_DL_DELAY)]  = flags_adv.ul && flags_adv.dld;
    applies[$clog2(PH_UL_DELAY)]  = flags_adv.ul && flags_adv.uld;
    applies[$clog2(PH_UL_SEQ)]    = flags_adv.ul && flags_adv.snp;
    applies[$clog2(PH_PAD)]       = (pad_need != 2'd0);
    above  = ~((phase_q << 1) - PhaseW'(1));
    cand   = applies & above;
    lowest = cand & (~cand + PhaseW'(1));
    nxt_ph = (cand == '0) ? PH_IDLE : phase_e'(lowest);
  end

  always_comb begin
    phase_d = phase_q;
    bytes_d = bytes_q;
    acc_d   = acc_q;
    flags_d = flags_q;
    hdr_d   = hdr_q;
    cnt_d   = cnt_q;
    pad_d   = pad_q;
    emit    = 1'b0;
    kind_d  = KIND_HEADER;
    value_d = '0;
    last_d  = 1'b0;

    if (accept) begin
      if (start_req_i) begin
        phase_d = PH_IDLE;
        bytes_d = '0;
        acc_d   = '0;
        flags_d = '0;
        hdr_d   = '0;
        cnt_d   = '0;
        pad_d   = '0;
        if (data_byte_i[7:4] == PduTypeDl) begin
          flags_d.snp = data_byte_i[2];
          flags_d.qmp = data_byte_i[3];
          cnt_d       = 2'd1;
          phase_d     = PH_OCT2;
        end else if (data_byte_i[7:4] == PduTypeUl) begin
          flags_d.ul  = 1'b1;
          flags_d.snp = data_byte_i[0];
          flags_d.uld = data_byte_i[1];
          flags_d.dld = data_byte_i[2];
          flags_d.qmp = data_byte_i[3];
          cnt_d       = 2'd1;
          phase_d     = PH_OCT2;
        end else begin
          emit   = 1'b1;
          kind_d = KIND_ERROR;
          last_d = 1'b1;
        end
      end else if (phase_q != PH_IDLE) begin
        cnt_d   = cnt_inc;
        flags_d = flags_adv;
        unique case (phase_q)
          PH_OCT2: begin
            hdr_d.qfi = data_byte_i[5:0];
            hdr_d.rqi = !flags_q.ul && data_byte_i[6];
            hdr_d.ppi = '0;
            phase_d   = nxt_ph;
            bytes_d   = field_len(nxt_ph);
            acc_d     = '0;
            pad_d     = pad_need;
            emit      = (nxt_ph != PH_PPI);
            last_d    = (nxt_ph == PH_IDLE);
          end
          PH_PPI: begin
            hdr_d.ppi = data_byte_i[7:5];
            phase_d   = nxt_ph;
            bytes_d   = field_len(nxt_ph);
            acc_d     = '0;
            pad_d     = pad_need;
            emit      = 1'b1;
            last_d    = (nxt_ph == PH_IDLE);
          end
          PH_PAD: begin
            if (pad_q > 2'd1) begin
              pad_d = pad_q - 2'd1;
            end else begin
              pad_d   = '0;
              phase_d = PH_IDLE;
              emit    = 1'b1;
              kind_d  = KIND_PAD_DONE;
              last_d  = 1'b1;
            end
          end
          default: begin
            acc_d = acc_shift;
            if (bytes_q > 4'd1) begin
              bytes_d = bytes_q - 4'd1;
            end else begin
              phase_d = nxt_ph;
              bytes_d = field_len(nxt_ph);
              acc_d   = '0;
              pad_d   = pad_need;
              emit    = 1'b1;
              kind_d  = field_kind(phase_q);
              value_d = acc_shift;
              last_d  = (nxt_ph == PH_IDLE);
            end
          end
        endcase
      end
    end
  end

  assign out_valid_d = (accept && emit) ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bytes_q     <= '0;
      acc_q       <= '0;
      flags_q     <= '0;
      hdr_q       <= '0;
      cnt_q       <= '0;
      pad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      bytes_q     <= bytes_d;
      acc_q       <= acc_d;
      flags_q     <= flags_d;
      hdr_q       <= hdr_d;
      cnt_q       <= cnt_d;
      pad_q       <= pad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q   <= kind_d;
      value_q  <= value_d;
      last_q   <= last_d;
      oflags_q <= flags_d;
      ohdr_q   <= hdr_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign value_o       = value_q;
  assign pdu_type_o    = oflags_q.ul;
  assign qmp_o         = oflags_q.qmp;
  assign qfi_o         = ohdr_q.qfi;
  assign rqi_o         = ohdr_q.rqi;
  assign ppi_present_o = oflags_q.ppp;
  assign ppi_o         = ohdr_q.ppi;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  // a bad pdu type start gives an error beat right away
  a_bad_type_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && start_req_i && (data_byte_i[7:5] != 3'd0)
    |=> out_valid_o && kind_o == KIND_ERROR)
    else $error("bad pdu type did not give an error beat");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERROR
    |-> last_o && !pdu_type_o && !qmp_o && qfi_o == 6'd0 && !ppi_present_o)
    else $error("error beat carries header values or lacks last");

  a_pad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PAD_DONE |-> last_o)
    else $error("padding_done beat without last");

  a_ul_no_dl_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pdu_type_o |-> !rqi_o && !ppi_present_o && ppi_o == 3'd0)
    else $error("uplink beat carries downlink-only header bits");
`endif

endmodule
